>>> rtl/ambr_pkg.sv
// ----------------------------------------------------------------------------
// ambr_pkg
// Shared types, constants and register map of the ambient/motion LED dimmer.
// ----------------------------------------------------------------------------
package ambr_pkg;

  // field widths
  localparam int unsigned LUX_W   = 16;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STEP_W  = 7;
  localparam int unsigned SQ_W    = 14;  // holds 126^2
  localparam int unsigned NUM_W   = LEVEL_W + SQ_W;
  localparam int unsigned FRAC_W  = 22;  // reciprocal scale, >= NUM_W
  localparam int unsigned RECIP_W = FRAC_W + 1;
  localparam int unsigned PROD_W  = NUM_W + RECIP_W;

  // configuration port
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned INDEX_W = 3;

  localparam logic [INDEX_W-1:0] REG_LUX_OFF    = 3'd0;
  localparam logic [INDEX_W-1:0] REG_LUX_MID    = 3'd1;
  localparam logic [INDEX_W-1:0] REG_LUX_LOW    = 3'd2;
  localparam logic [INDEX_W-1:0] REG_LVL_BRIGHT = 3'd3;
  localparam logic [INDEX_W-1:0] REG_LVL_MEDIUM = 3'd4;
  localparam logic [INDEX_W-1:0] REG_LVL_DARK   = 3'd5;
  localparam logic [INDEX_W-1:0] REG_FULL_LEVEL = 3'd6;
  localparam logic [INDEX_W-1:0] REG_TIMEOUT    = 3'd7;

  localparam logic [LUX_W-1:0]   RST_LUX_OFF    = 16'd500;
  localparam logic [LUX_W-1:0]   RST_LUX_MID    = 16'd300;
  localparam logic [LUX_W-1:0]   RST_LUX_LOW    = 16'd100;
  localparam logic [LEVEL_W-1:0] RST_LVL_BRIGHT = 8'd50;
  localparam logic [LEVEL_W-1:0] RST_LVL_MEDIUM = 8'd80;
  localparam logic [LEVEL_W-1:0] RST_LVL_DARK   = 8'd110;
  localparam logic [LEVEL_W-1:0] RST_FULL_LEVEL = 8'd255;
  localparam logic [TIME_W-1:0]  RST_TIMEOUT    = 32'd5000;

  // ramp lengths, valid range 1..126
  localparam int unsigned UP_STEPS_DEF   = 40;
  localparam int unsigned DOWN_STEPS_DEF = 60;

  // opcodes
  localparam logic [OP_W-1:0] OP_TRIGGER = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [TIME_W-1:0] time_ms;
    logic [LUX_W-1:0]  lux;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               motion_active;
  } out_t;

  typedef struct packed {
    logic [LUX_W-1:0]   lux_off_threshold;
    logic [LUX_W-1:0]   lux_mid_threshold;
    logic [LUX_W-1:0]   lux_low_threshold;
    logic [LEVEL_W-1:0] level_bright_ambient;
    logic [LEVEL_W-1:0] level_medium;
    logic [LEVEL_W-1:0] level_dark;
    logic [LEVEL_W-1:0] full_level;
    logic [TIME_W-1:0]  motion_timeout_ms;
  } cfg_t;

  // controller -> datapath commands
  typedef struct packed {
    logic trig;
    logic cancel;
    logic load;
    logic base;
    logic plan;
    logic sq;
    logic num;
    logic rec;
    logic corr;
    logic emit;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic arith;  // plan step needs the curve arithmetic
  } sts_t;

endpackage

>>> rtl/ambr_regs.sv
// ----------------------------------------------------------------------------
// ambr_regs
// APB-style configuration registers: thresholds, levels and motion timeout.
// ----------------------------------------------------------------------------
module ambr_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ambr_pkg::ADDR_W-1:0]  paddr,
  input  logic [ambr_pkg::DATA_W-1:0]  pwdata,
  output logic [ambr_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output ambr_pkg::cfg_t               cfg_o
);

  ambr_pkg::cfg_t                 cfg_q;
  logic                           wr_en;
  logic [ambr_pkg::INDEX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[ambr_pkg::ADDR_W-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lux_off_threshold    <= ambr_pkg::RST_LUX_OFF;
      cfg_q.lux_mid_threshold    <= ambr_pkg::RST_LUX_MID;
      cfg_q.lux_low_threshold    <= ambr_pkg::RST_LUX_LOW;
      cfg_q.level_bright_ambient <= ambr_pkg::RST_LVL_BRIGHT;
      cfg_q.level_medium         <= ambr_pkg::RST_LVL_MEDIUM;
      cfg_q.level_dark           <= ambr_pkg::RST_LVL_DARK;
      cfg_q.full_level           <= ambr_pkg::RST_FULL_LEVEL;
      cfg_q.motion_timeout_ms    <= ambr_pkg::RST_TIMEOUT;
    end else if (wr_en) begin
      unique case (idx)
        ambr_pkg::REG_LUX_OFF:    cfg_q.lux_off_threshold    <= pwdata[ambr_pkg::LUX_W-1:0];
        ambr_pkg::REG_LUX_MID:    cfg_q.lux_mid_threshold    <= pwdata[ambr_pkg::LUX_W-1:0];
        ambr_pkg::REG_LUX_LOW:    cfg_q.lux_low_threshold    <= pwdata[ambr_pkg::LUX_W-1:0];
        ambr_pkg::REG_LVL_BRIGHT: cfg_q.level_bright_ambient <= pwdata[ambr_pkg::LEVEL_W-1:0];
        ambr_pkg::REG_LVL_MEDIUM: cfg_q.level_medium         <= pwdata[ambr_pkg::LEVEL_W-1:0];
        ambr_pkg::REG_LVL_DARK:   cfg_q.level_dark           <= pwdata[ambr_pkg::LEVEL_W-1:0];
        ambr_pkg::REG_FULL_LEVEL: cfg_q.full_level           <= pwdata[ambr_pkg::LEVEL_W-1:0];
        ambr_pkg::REG_TIMEOUT:    cfg_q.motion_timeout_ms    <= pwdata[ambr_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      ambr_pkg::REG_LUX_OFF:    prdata = ambr_pkg::DATA_W'(cfg_q.lux_off_threshold);
      ambr_pkg::REG_LUX_MID:    prdata = ambr_pkg::DATA_W'(cfg_q.lux_mid_threshold);
      ambr_pkg::REG_LUX_LOW:    prdata = ambr_pkg::DATA_W'(cfg_q.lux_low_threshold);
      ambr_pkg::REG_LVL_BRIGHT: prdata = ambr_pkg::DATA_W'(cfg_q.level_bright_ambient);
      ambr_pkg::REG_LVL_MEDIUM: prdata = ambr_pkg::DATA_W'(cfg_q.level_medium);
      ambr_pkg::REG_LVL_DARK:   prdata = ambr_pkg::DATA_W'(cfg_q.level_dark);
      ambr_pkg::REG_FULL_LEVEL: prdata = ambr_pkg::DATA_W'(cfg_q.full_level);
      ambr_pkg::REG_TIMEOUT:    prdata = ambr_pkg::DATA_W'(cfg_q.motion_timeout_ms);
      default:                  prdata = '0;
    endcase
  end

endmodule

>>> rtl/ambr_ctrl.sv
// ----------------------------------------------------------------------------
// ambr_ctrl
// Sequencer: takes input words, steps the datapath through a tick, and owns
// the output valid flag.
// ----------------------------------------------------------------------------
module ambr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ambr_pkg::OP_W-1:0]     opcode_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  ambr_pkg::sts_t                sts_i,
  output ambr_pkg::cmd_t                cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BASE = 3'd1;
  localparam logic [2:0] S_PLAN = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_NUM  = 3'd4;
  localparam logic [2:0] S_REC  = 3'd5;
  localparam logic [2:0] S_CORR = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (opcode_i)
            ambr_pkg::OP_TRIGGER: cmd_o.trig   = 1'b1;
            ambr_pkg::OP_CANCEL:  cmd_o.cancel = 1'b1;
            ambr_pkg::OP_TICK: begin
              cmd_o.load = 1'b1;
              state_d    = S_BASE;
            end
            default: ;  // unused opcode: dropped
          endcase
        end
      end
      S_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = S_PLAN;
      end
      S_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = sts_i.arith ? S_SQ : S_OUT;
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = S_NUM;
      end
      S_NUM: begin
        cmd_o.num = 1'b1;
        state_d   = S_REC;
      end
      S_REC: begin
        cmd_o.rec = 1'b1;
        state_d   = S_CORR;
      end
      S_CORR: begin
        cmd_o.corr = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        // output slot free or being drained this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/ambr_dp.sv
// ----------------------------------------------------------------------------
// ambr_dp
// Datapath: motion flag, lux banding, ramp bookkeeping and the curve
// arithmetic floor(diff*sq/N^2) via a reciprocal multiply plus one correction.
// ----------------------------------------------------------------------------
module ambr_dp #(
  parameter int unsigned UP_STEPS   = ambr_pkg::UP_STEPS_DEF,
  parameter int unsigned DOWN_STEPS = ambr_pkg::DOWN_STEPS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ambr_pkg::cfg_t  cfg_i,
  input  ambr_pkg::in_t   in_data_i,
  input  ambr_pkg::cmd_t  cmd_i,
  output ambr_pkg::sts_t  sts_o,
  output ambr_pkg::out_t  out_data_o
);

  localparam int unsigned LW = ambr_pkg::LEVEL_W;
  localparam int unsigned SW = ambr_pkg::STEP_W;
  localparam int unsigned QW = ambr_pkg::SQ_W;
  localparam int unsigned NW = ambr_pkg::NUM_W;
  localparam int unsigned RW = ambr_pkg::RECIP_W;
  localparam int unsigned PW = ambr_pkg::PROD_W;
  localparam int unsigned FW = ambr_pkg::FRAC_W;

  localparam logic [SW-1:0] UP_LIM   = SW'(UP_STEPS);
  localparam logic [SW-1:0] DN_LIM   = SW'(DOWN_STEPS);
  localparam logic [QW-1:0] UP_SQ    = QW'(UP_STEPS * UP_STEPS);
  localparam logic [QW-1:0] DN_SQ    = QW'(DOWN_STEPS * DOWN_STEPS);
  localparam logic [RW-1:0] UP_RECIP = RW'((2 ** FW) / (UP_STEPS * UP_STEPS));
  localparam logic [RW-1:0] DN_RECIP = RW'((2 ** FW) / (DOWN_STEPS * DOWN_STEPS));

  // architectural state
  logic                               motion_q;
  logic [ambr_pkg::TIME_W-1:0]        last_q;
  logic [LW-1:0]                      cur_q;
  logic [LW-1:0]                      start_q;
  logic [SW-1:0]                      step_q;
  logic                               up_q, dn_q;

  // per-tick working registers
  logic [ambr_pkg::TIME_W-1:0]        time_q;
  logic [ambr_pkg::LUX_W-1:0]         lux_q;
  logic [LW-1:0]                      base_q;
  logic [LW-1:0]                      diff_q;
  logic [SW-1:0]                      s_q;
  logic                               dir_up_q;
  logic [QW-1:0]                      sq_q;
  logic [NW-1:0]                      num_q;
  logic [LW-1:0]                      q0_q;
  ambr_pkg::out_t                     out_q;

  // base level and timeout
  logic [LW-1:0]                      base_d;
  logic [ambr_pkg::TIME_W-1:0]        elapsed;
  logic                               expire;

  always_comb begin
    if (lux_q >= cfg_i.lux_off_threshold) begin
      base_d = '0;
    end else if (lux_q >= cfg_i.lux_mid_threshold) begin
      base_d = cfg_i.level_bright_ambient;
    end else if (lux_q >= cfg_i.lux_low_threshold) begin
      base_d = cfg_i.level_medium;
    end else begin
      base_d = cfg_i.level_dark;
    end
  end

  assign elapsed = time_q - last_q;  // wraps mod 2^32
  assign expire  = motion_q && (elapsed > cfg_i.motion_timeout_ms);

  // ramp planning
  logic [LW-1:0] target;
  logic          start_up, start_dn;
  logic          gu, gd;
  logic [SW-1:0] step0, step1;
  logic [LW-1:0] sl;
  logic          up_d, dn_d, arith_d, dir_up_d;
  logic [SW-1:0] step_d, s_d;
  logic [LW-1:0] cur_d, diff_d;

  always_comb begin
    target   = ((base_q != '0) && motion_q) ? cfg_i.full_level : base_q;
    start_up = (target > cur_q) && !up_q;
    start_dn = (target < cur_q) && !dn_q;
    gu       = start_up ? 1'b1 : (start_dn ? 1'b0 : up_q);
    gd       = start_dn ? 1'b1 : (start_up ? 1'b0 : dn_q);
    step0    = (start_up || start_dn) ? '0 : step_q;
    sl       = (start_up || start_dn) ? cur_q : start_q;
    step1    = step0 + SW'(1);

    up_d     = gu;
    dn_d     = gd;
    step_d   = step0;
    cur_d    = cur_q;
    arith_d  = 1'b0;
    dir_up_d = 1'b1;
    diff_d   = '0;
    s_d      = '0;

    if (gu && (cur_q < target)) begin
      step_d = step1;
      if (step1 <= UP_LIM) begin
        arith_d  = 1'b1;
        dir_up_d = 1'b1;
        diff_d   = (target > sl) ? target - sl : '0;
        s_d      = step1;
      end else begin
        cur_d = target;
        up_d  = 1'b0;
      end
    end else if (gd && (cur_q > target)) begin
      step_d = step1;
      if (step1 <= DN_LIM) begin
        arith_d  = 1'b1;
        dir_up_d = 1'b0;
        diff_d   = (sl > target) ? sl - target : '0;
        s_d      = DN_LIM - step1;  // steps remaining
      end else begin
        cur_d = target;
        dn_d  = 1'b0;
      end
    end else begin
      up_d = 1'b0;
      dn_d = 1'b0;
    end
  end

  assign sts_o.arith = arith_d;

  // curve arithmetic
  logic [QW-1:0] sqr;
  logic [QW-1:0] sq_d;
  logic [NW-1:0] num_d;
  logic [PW-1:0] prod;
  logic [QW-1:0] divisor;
  logic [NW-1:0] qd;
  logic [NW-1:0] rem;
  logic [LW-1:0] q;
  logic [LW-1:0] curve_lvl;

  assign sqr   = QW'(s_q) * QW'(s_q);
  // falling ramp uses N^2 - rem^2
  assign sq_d  = dir_up_q ? sqr : DN_SQ - sqr;
  assign num_d = NW'(diff_q) * NW'(sq_q);
  assign prod  = PW'(num_q) * PW'(dir_up_q ? UP_RECIP : DN_RECIP);

  // reciprocal estimate is exact or one low
  assign divisor   = dir_up_q ? UP_SQ : DN_SQ;
  assign qd        = NW'(q0_q) * NW'(divisor);
  assign rem       = num_q - qd;
  assign q         = (rem >= NW'(divisor)) ? q0_q + LW'(1) : q0_q;
  assign curve_lvl = dir_up_q ? start_q + q : start_q - q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_q <= 1'b0;
      last_q   <= '0;
      cur_q    <= '0;
      start_q  <= '0;
      step_q   <= '0;
      up_q     <= 1'b0;
      dn_q     <= 1'b0;
    end else begin
      if (cmd_i.trig) begin
        motion_q <= 1'b1;
        last_q   <= in_data_i.time_ms;
      end
      if (cmd_i.cancel) begin
        motion_q <= 1'b0;
      end
      if (cmd_i.base && expire) begin
        motion_q <= 1'b0;
      end
      if (cmd_i.plan) begin
        up_q    <= up_d;
        dn_q    <= dn_d;
        step_q  <= step_d;
        start_q <= sl;
        cur_q   <= cur_d;
      end
      if (cmd_i.corr) begin
        cur_q <= curve_lvl;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      time_q <= in_data_i.time_ms;
      lux_q  <= in_data_i.lux;
    end
    if (cmd_i.base) begin
      base_q <= base_d;
    end
    if (cmd_i.plan) begin
      diff_q   <= diff_d;
      s_q      <= s_d;
      dir_up_q <= dir_up_d;
    end
    if (cmd_i.sq) begin
      sq_q <= sq_d;
    end
    if (cmd_i.num) begin
      num_q <= num_d;
    end
    if (cmd_i.rec) begin
      q0_q <= prod[FW+LW-1:FW];
    end
    if (cmd_i.emit) begin
      out_q.level         <= cur_q;
      out_q.motion_active <= motion_q;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/ambient_motion_brightness_ramp_top.sv
// Trigger and cancel words finish in their accept cycle and give no result.
// A tick steps through base and plan, then, when a curve point is needed, through
// square, product, reciprocal multiply and fix-up; it holds until the output is free.
// A new word is taken the cycle after the result is registered: a tick must
// finish before the next word is taken, as the sequencer only accepts when idle.
// rst_ni clears config to defaults, the motion flag, the level and ramp state.
// ----------------------------------------------------------------------------
// ambient_motion_brightness_ramp_top
// LED dimmer driven by ambient lux and motion, with square-law ramps.
// ----------------------------------------------------------------------------
module ambient_motion_brightness_ramp_top #(
  parameter int unsigned UP_STEPS   = ambr_pkg::UP_STEPS_DEF,
  parameter int unsigned DOWN_STEPS = ambr_pkg::DOWN_STEPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ambr_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ambr_pkg::out_t               out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ambr_pkg::ADDR_W-1:0]  paddr,
  input  logic [ambr_pkg::DATA_W-1:0]  pwdata,
  output logic [ambr_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  ambr_pkg::cfg_t cfg;
  ambr_pkg::cmd_t cmd;
  ambr_pkg::sts_t sts;

  ambr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ambr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (in_data_i.opcode),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ambr_dp #(
    .UP_STEPS   (UP_STEPS),
    .DOWN_STEPS (DOWN_STEPS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("multiple datapath commands");

  // an accepted tick keeps the block busy
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.opcode == ambr_pkg::OP_TICK) |=> !in_ready_o)
    else $error("ready after tick accept");

  // trigger, cancel and unused words finish in the accept cycle
  a_short_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.opcode != ambr_pkg::OP_TICK) |=> in_ready_o)
    else $error("non-tick word stalled the block");

  // a result only appears after the datapath captured it
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.emit))
    else $error("output valid without emit");
`endif

endmodule
